// ----- rtl/lrhb_pkg.sv -----
// Shared types, constants and the byte-wide CRC-32 update for the record header builder.
`timescale 1ns / 1ps
`default_nettype none

package lrhb_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_TYPE  = 2'd0,
      ACT_KEY   = 2'd1,
      ACT_VALUE = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_KEY   = 2'd1,
      PHASE_VALUE = 2'd2
   } phase_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  data_byte;
      logic        end_of_record;
   } item_type;

   typedef struct packed {
      logic [31:0] checksum;
      logic [7:0]  record_type;
      logic [31:0] key_length;
      logic [31:0] value_length;
      logic [33:0] record_length;
      logic        order_error;
   } result_type;

   // Reflected CRC-32, one byte, LSB first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == CRC_ONES) ? v : v + 32'd1;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lrhb_in_reg.sv -----
// Input register stage: captures one request transfer and holds it until the framer takes it.
`timescale 1ns / 1ps
`default_nettype none

module lrhb_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lrhb_pkg::item_type req_item,
   output logic                   item_valid,
   output lrhb_pkg::item_type     item,
   input  wire logic              item_take
);

   logic               valid_ff, valid_in;
   lrhb_pkg::item_type item_ff, item_in;
   logic               load;

   // Refill whenever the slot is empty or drains this cycle.
   assign load = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = req_valid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign req_stall  = !load;
   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- rtl/lrhb_framer.sv -----
// Record state, CRC update, header; one item per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module lrhb_framer #(
   parameter int HEADER_BYTES = 13
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire lrhb_pkg::item_type item,
   output logic                    item_take,
   input  wire logic               res_free,
   output logic                    res_load,
   output lrhb_pkg::result_type    res_data
);

   logic [31:0]         crc_ff, crc_in, crc_upd;
   logic [31:0]         kcnt_ff, kcnt_in, kcnt_upd;
   logic [31:0]         vcnt_ff, vcnt_in, vcnt_upd;
   logic [7:0]          type_ff, type_in, type_upd;
   lrhb_pkg::phase_type phase_ff, phase_in, phase_upd;
   logic                err_ff, err_in, err_upd;
   logic                emits;

   assign emits     = item.end_of_record && (item.action != lrhb_pkg::ACT_NONE);
   assign item_take = item_valid && (!emits || res_free);
   assign res_load  = item_take && emits;

   // Fold this byte into the record state.
   always_comb begin
      crc_upd   = crc_ff;
      kcnt_upd  = kcnt_ff;
      vcnt_upd  = vcnt_ff;
      type_upd  = type_ff;
      phase_upd = phase_ff;
      err_upd   = err_ff;
      unique case (item.action)
         lrhb_pkg::ACT_TYPE: begin
            crc_upd   = lrhb_pkg::crc_byte(lrhb_pkg::CRC_ONES, item.data_byte);
            kcnt_upd  = 32'd0;
            vcnt_upd  = 32'd0;
            type_upd  = item.data_byte;
            phase_upd = lrhb_pkg::PHASE_KEY;
            err_upd   = 1'b0;
         end
         lrhb_pkg::ACT_KEY: begin
            if (phase_ff != lrhb_pkg::PHASE_KEY) begin
               err_upd = 1'b1;
            end
            if (phase_ff == lrhb_pkg::PHASE_IDLE) begin
               phase_upd = lrhb_pkg::PHASE_KEY;
            end
            crc_upd  = lrhb_pkg::crc_byte(crc_ff, item.data_byte);
            kcnt_upd = lrhb_pkg::sat_inc(kcnt_ff);
         end
         lrhb_pkg::ACT_VALUE: begin
            if (phase_ff == lrhb_pkg::PHASE_IDLE) begin
               err_upd = 1'b1;
            end
            phase_upd = lrhb_pkg::PHASE_VALUE;
            crc_upd   = lrhb_pkg::crc_byte(crc_ff, item.data_byte);
            vcnt_upd  = lrhb_pkg::sat_inc(vcnt_ff);
         end
         lrhb_pkg::ACT_NONE: begin
            // unused code: hold everything
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      res_data.checksum      = crc_upd ^ lrhb_pkg::CRC_ONES;
      res_data.record_type   = type_upd;
      res_data.key_length    = kcnt_upd;
      res_data.value_length  = vcnt_upd;
      res_data.record_length = 34'(HEADER_BYTES) + {2'b00, kcnt_upd} + {2'b00, vcnt_upd};
      res_data.order_error   = err_upd;
   end

   // Drop back to the reset state after a header goes out.
   always_comb begin
      crc_in   = crc_ff;
      kcnt_in  = kcnt_ff;
      vcnt_in  = vcnt_ff;
      type_in  = type_ff;
      phase_in = phase_ff;
      err_in   = err_ff;
      if (item_take) begin
         if (emits) begin
            crc_in   = lrhb_pkg::CRC_ONES;
            kcnt_in  = 32'd0;
            vcnt_in  = 32'd0;
            type_in  = 8'd0;
            phase_in = lrhb_pkg::PHASE_IDLE;
            err_in   = 1'b0;
         end else begin
            crc_in   = crc_upd;
            kcnt_in  = kcnt_upd;
            vcnt_in  = vcnt_upd;
            type_in  = type_upd;
            phase_in = phase_upd;
            err_in   = err_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= lrhb_pkg::CRC_ONES;
         kcnt_ff  <= 32'd0;
         vcnt_ff  <= 32'd0;
         type_ff  <= 8'd0;
         phase_ff <= lrhb_pkg::PHASE_IDLE;
         err_ff   <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         kcnt_ff  <= kcnt_in;
         vcnt_ff  <= vcnt_in;
         type_ff  <= type_in;
         phase_ff <= phase_in;
         err_ff   <= err_in;
      end
   end

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      res_load |-> res_free)
      else $error("header loaded while result register is occupied");

   a_reset_after_header: assert property (@(posedge clock) disable iff (reset)
      res_load |=> (crc_ff == lrhb_pkg::CRC_ONES && kcnt_ff == 32'd0 && vcnt_ff == 32'd0
                    && phase_ff == lrhb_pkg::PHASE_IDLE && !err_ff))
      else $error("record state not cleared after header");

   a_unused_holds: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.action == lrhb_pkg::ACT_NONE)
      |=> ($stable(crc_ff) && $stable(kcnt_ff) && $stable(vcnt_ff) && $stable(phase_ff)))
      else $error("unused action code changed record state");

   a_type_opens_clean: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.action == lrhb_pkg::ACT_TYPE && !item.end_of_record)
      |=> (phase_ff == lrhb_pkg::PHASE_KEY && !err_ff && kcnt_ff == 32'd0))
      else $error("type byte did not open a clean record");

endmodule

`default_nettype wire

// ----- rtl/lrhb_out_reg.sv -----
// Result register: holds one header until the response side takes it.
`timescale 1ns / 1ps
`default_nettype none

module lrhb_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 res_load,
   input  wire lrhb_pkg::result_type res_data,
   output logic                      res_free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output lrhb_pkg::result_type      rsp_data
);

   logic                 valid_ff, valid_in;
   lrhb_pkg::result_type data_ff, data_in;

   assign res_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (res_load) begin
         valid_in = 1'b1;
         data_in  = res_data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/log_record_header_builder_top.sv -----
// Top level of the log record header builder: input register, framer, result register.
// The end byte is registered in the input register and its header in the result register before rsp_valid rises.
// Throughput: one byte per cycle while req_stall is low; the combinational CRC byte update and counters set the pace.
// Only a held header with rsp_stall high backs up into req_stall.
// Reset (synchronous, active high) empties both registers, sets the CRC to all ones,
// and clears counts, type, phase and the order error flag.
`timescale 1ns / 1ps
`default_nettype none

module log_record_header_builder_top #(
   parameter int HEADER_BYTES = 13
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_record,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_checksum,
   output logic [7:0]       rsp_record_type,
   output logic [31:0]      rsp_key_length,
   output logic [31:0]      rsp_value_length,
   output logic [33:0]      rsp_record_length,
   output logic             rsp_order_error
);

   lrhb_pkg::item_type   req_item;
   lrhb_pkg::item_type   item;
   logic                 item_valid;
   logic                 item_take;
   logic                 res_free;
   logic                 res_load;
   lrhb_pkg::result_type res_data;
   lrhb_pkg::result_type rsp_data;

   // Bundle the request fields into one item.
   always_comb begin
      req_item.action        = lrhb_pkg::action_type'(req_action);
      req_item.data_byte     = req_data_byte;
      req_item.end_of_record = req_end_of_record;
   end

   // Stage one: register each request transfer.
   lrhb_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // Stage two: advance the record state; a byte without a header result never waits on
   // the response side, a byte that ends a record waits only for room in the result register.
   lrhb_framer #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .res_free   (res_free),
      .res_load   (res_load),
      .res_data   (res_data)
   );

   // Result register: hold the header until its transfer completes.
   lrhb_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_load  (res_load),
      .res_data  (res_data),
      .res_free  (res_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_checksum      = rsp_data.checksum;
   assign rsp_record_type   = rsp_data.record_type;
   assign rsp_key_length    = rsp_data.key_length;
   assign rsp_value_length  = rsp_data.value_length;
   assign rsp_record_length = rsp_data.record_length;
   assign rsp_order_error   = rsp_data.order_error;

endmodule

`default_nettype wire
